// File: rtl/hkm_pkg.sv
// hkm_pkg: shared types and constants for the heartbeat keepalive monitor.
// Used by hkm_cfg, hkm_core and heartbeat_keepalive_monitor.
package hkm_pkg;

  localparam int TIME_BITS = 48;
  localparam int PADDR_BITS = 3;

  localparam logic [15:0] PERIOD_RST  = 16'd1000;
  localparam logic [3:0]  RETRIES_RST = 4'd3;

  typedef enum logic [0:0] {
    REG_PERIOD  = 1'b0,
    REG_RETRIES = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_READ       = 3'd1,
    REQ_PONG       = 3'd2,
    REQ_CONNECT    = 3'd3,
    REQ_DISCONNECT = 3'd4
  } req_t;

  typedef struct packed {
    logic [15:0] heartbeat_period_ms;
    logic [3:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    logic [2:0]           req_type;
    logic [TIME_BITS-1:0] now_ms;
    logic [TIME_BITS-1:0] pong_time_ms;
  } item_t;

  typedef struct packed {
    logic               send_ping;
    logic               drop_link;
    logic signed [31:0] rtt_ms;
    logic signed [31:0] min_rtt_ms;
    logic signed [31:0] max_rtt_ms;
    logic [3:0]         retries_left;
    logic [63:0]        idle_time_ms;
    logic [63:0]        work_time_ms;
  } result_t;

endpackage

// File: rtl/hkm_cfg.sv
// hkm_cfg: APB-style register file holding the heartbeat period and retry limit.
// Depends on hkm_pkg.
module hkm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hkm_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output hkm_pkg::cfg_t                  cfg
);
  import hkm_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heartbeat_period_ms <= PERIOD_RST;
      cfg.max_retries         <= RETRIES_RST;
    end else if (wr) begin
      case (idx)
        REG_PERIOD:  cfg.heartbeat_period_ms <= pwdata[15:0];
        REG_RETRIES: cfg.max_retries         <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PERIOD:  prdata = {16'd0, cfg.heartbeat_period_ms};
      REG_RETRIES: prdata = {28'd0, cfg.max_retries};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/hkm_core.sv
// hkm_core: link state registers and the single-pass event update logic.
// Depends on hkm_pkg; result is combinational from the next state.
module hkm_core (
  input  logic             clk,
  input  logic             rst,
  input  hkm_pkg::cfg_t    cfg,
  input  hkm_pkg::item_t   item,
  input  logic             fire,
  output hkm_pkg::result_t res
);
  import hkm_pkg::*;

  logic                 connected, connected_next;
  logic [TIME_BITS-1:0] last_read_time, last_read_time_next;
  logic                 ping_sent, ping_sent_next;
  logic [TIME_BITS-1:0] last_pong_time, last_pong_time_next;
  logic signed [31:0]   rtt_value, rtt_value_next;
  logic signed [31:0]   min_rtt, min_rtt_next;
  logic signed [31:0]   max_rtt, max_rtt_next;
  logic [3:0]           retry_count, retry_count_next;
  logic [63:0]          idle_total, idle_total_next;
  logic [63:0]          work_total, work_total_next;

  logic [TIME_BITS-1:0] quiet, since, diff;
  logic signed [37:0]   period_s, max_ext, thr, d_ext, d20;
  logic signed [63:0]   sd;
  logic signed [31:0]   d;
  logic                 lost, ping, drop, clear;

  // elapsed times and thresholds
  always_comb begin
    quiet    = item.now_ms - last_read_time;
    since    = item.now_ms - last_pong_time;
    diff     = item.now_ms - item.pong_time_ms;
    period_s = $signed({22'd0, cfg.heartbeat_period_ms});
    max_ext  = 38'(max_rtt);
    thr      = period_s + (max_ext <<< 3) + (max_ext <<< 1);
    lost     = (rtt_value < 0) || thr[37] || (64'(since) > 64'(unsigned'(thr)));
    sd       = 64'(signed'(diff));
    if (sd < -64'sd2147483648) begin
      d = 32'sh8000_0000;
    end else if (sd > 64'sd2147483647) begin
      d = 32'sh7fff_ffff;
    end else begin
      d = sd[31:0];
    end
    d_ext = 38'(d);
    d20   = (d_ext <<< 4) + (d_ext <<< 2);
  end

  always_comb begin
    connected_next      = connected;
    last_read_time_next = last_read_time;
    ping_sent_next      = ping_sent;
    last_pong_time_next = last_pong_time;
    rtt_value_next      = rtt_value;
    min_rtt_next        = min_rtt;
    max_rtt_next        = max_rtt;
    retry_count_next    = retry_count;
    idle_total_next     = idle_total;
    work_total_next     = work_total;
    ping                = 1'b0;
    drop                = 1'b0;
    clear               = 1'b0;
    case (item.req_type)
      REQ_TICK: begin
        if (!connected) begin
          idle_total_next = idle_total + 64'(cfg.heartbeat_period_ms);
        end else begin
          work_total_next = work_total + 64'(cfg.heartbeat_period_ms);
          if (quiet >= TIME_BITS'(cfg.heartbeat_period_ms)) begin
            if (retry_count == 4'd0) begin
              clear = 1'b1;
              drop  = 1'b1;
            end else begin
              if (ping_sent && lost) begin
                retry_count_next = retry_count - 4'd1;
              end
              ping_sent_next = 1'b1;
              ping           = 1'b1;
            end
          end
        end
      end
      REQ_READ: begin
        if (connected) begin
          last_read_time_next = item.now_ms;
        end
      end
      REQ_PONG: begin
        if (connected) begin
          last_pong_time_next = item.now_ms;
          rtt_value_next      = d;
          if (min_rtt > d) begin
            min_rtt_next = d;
          end
          if ((max_rtt < d) && (d20 < period_s)) begin
            max_rtt_next = d;
          end
          retry_count_next = cfg.max_retries;
        end
      end
      REQ_CONNECT: begin
        connected_next = 1'b1;
      end
      REQ_DISCONNECT: begin
        clear = 1'b1;
      end
      default: ;
    endcase
    if (clear) begin
      connected_next      = 1'b0;
      last_read_time_next = '0;
      ping_sent_next      = 1'b0;
      last_pong_time_next = '0;
      rtt_value_next      = -32'sd1;
      min_rtt_next        = $signed({16'd0, cfg.heartbeat_period_ms});
      max_rtt_next        = -$signed({16'd0, cfg.heartbeat_period_ms});
      retry_count_next    = cfg.max_retries;
    end
  end

  always_comb begin
    res.send_ping    = ping;
    res.drop_link    = drop;
    res.rtt_ms       = rtt_value_next;
    res.min_rtt_ms   = min_rtt_next;
    res.max_rtt_ms   = max_rtt_next;
    res.retries_left = retry_count_next;
    res.idle_time_ms = idle_total_next;
    res.work_time_ms = work_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connected      <= 1'b0;
      last_read_time <= '0;
      ping_sent      <= 1'b0;
      last_pong_time <= '0;
      rtt_value      <= -32'sd1;
      min_rtt        <= $signed({16'd0, PERIOD_RST});
      max_rtt        <= -$signed({16'd0, PERIOD_RST});
      retry_count    <= RETRIES_RST;
      idle_total     <= '0;
      work_total     <= '0;
    end else if (fire) begin
      connected      <= connected_next;
      last_read_time <= last_read_time_next;
      ping_sent      <= ping_sent_next;
      last_pong_time <= last_pong_time_next;
      rtt_value      <= rtt_value_next;
      min_rtt        <= min_rtt_next;
      max_rtt        <= max_rtt_next;
      retry_count    <= retry_count_next;
      idle_total     <= idle_total_next;
      work_total     <= work_total_next;
    end
  end

endmodule

// File: rtl/heartbeat_keepalive_monitor.sv
// heartbeat_keepalive_monitor: top level of the link keepalive monitor.
// Event channel in, one result word per event out, APB-style config port.
// Depends on hkm_pkg, hkm_cfg and hkm_core.
//
// Usage:
//   item / item_valid / item_ready carry one event word (tick, read, pong,
//   connect, disconnect). result / result_valid / result_ready return one
//   word per event: ping and drop flags, rtt statistics, retries left and
//   the idle and work time totals after the event.
//   The event word is registered in the input register when accepted; the
//   state update and result register load in one pass through hkm_core as
//   the word advances, once the result register is empty or being taken.
//   Throughput is one event per cycle while result_ready is high.
//   While result waits on result_ready the input register still takes one
//   more word; item_ready drops only when both registers are full.
//   Synchronous reset clears both stages, sets the period to 1000 ms and
//   the retry limit to 3, and returns the link state to disconnected.
//   The period and retry registers are written through psel/penable/pwrite
//   at byte addresses 0 and 4; pready is always high.
module heartbeat_keepalive_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  hkm_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output hkm_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hkm_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import hkm_pkg::*;

  cfg_t    cfg;
  item_t   stage;
  logic    stage_valid;
  logic    adv;
  result_t res;

  assign adv        = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || adv;

  hkm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hkm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (stage),
    .fire (adv),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      stage_valid  <= (item_valid && item_ready) || (stage_valid && !adv);
      result_valid <= adv || (result_valid && !result_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage <= item;
    end
    if (adv) begin
      result <= res;
    end
  end

endmodule

// File: dv/tb_top.sv
// tb_top: self-checking testbench for heartbeat_keepalive_monitor.
// Drives event words with bursty valid/ready and a stalling receiver, predicts each
// status word in-line, programs the period and retry registers over APB. Needs hkm_pkg.
`timescale 1ns / 1ps

module tb_top;
  import hkm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int EVENTS_PER_PHASE = 65;
  localparam longint RTT_HI = 64'sd2147483647;
  localparam longint RTT_LO = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  heartbeat_keepalive_monitor i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predicted link state and register copies
  logic [15:0] cfg_period;
  logic [3:0] cfg_retries;
  logic link_up;
  logic [TIME_BITS-1:0] last_read_ms;
  logic [TIME_BITS-1:0] last_pong_ms;
  logic ping_out;
  int rtt_now;
  int rtt_min;
  int rtt_max;
  logic [3:0] retries_left;
  logic [63:0] idle_ms;
  logic [63:0] work_ms;

  item_t pending_events[$];
  result_t status_due[$];
  result_t want;
  logic [TIME_BITS-1:0] t_now;
  int queued_events = 0;
  int events_in = 0;
  int status_seen = 0;
  int pings_seen = 0;
  int drops_seen = 0;
  int fails = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  logic item_fire = 1'b0;
  logic [31:0] rx_tick = '0;
  int rx_mode = 0;

  function automatic void clear_link_state();
    link_up = 1'b0;
    last_read_ms = '0;
    last_pong_ms = '0;
    ping_out = 1'b0;
    rtt_now = -1;
    rtt_min = int'(cfg_period);
    rtt_max = -int'(cfg_period);
    retries_left = cfg_retries;
  endfunction

  function automatic result_t keepalive_step(item_t w);
    result_t r;
    logic [TIME_BITS-1:0] quiet;
    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] dt;
    longint dl;
    longint thr;
    int d;
    logic lost;
    r = '0;
    case (w.req_type)
      REQ_TICK: begin
        if (!link_up) begin
          idle_ms += cfg_period;
        end else begin
          work_ms += cfg_period;
          quiet = w.now_ms - last_read_ms;
          if (quiet >= cfg_period) begin
            if (retries_left == 0) begin
              clear_link_state();
              r.drop_link = 1'b1;
            end else begin
              if (ping_out) begin
                lost = (rtt_now < 0);
                if (!lost) begin
                  thr = longint'(cfg_period) + 10 * longint'(rtt_max);
                  since = w.now_ms - last_pong_ms;
                  lost = (thr < 0) || (longint'({16'd0, since}) > thr);
                end
                if (lost) retries_left = retries_left - 4'd1;
              end
              ping_out = 1'b1;
              r.send_ping = 1'b1;
            end
          end
        end
      end
      REQ_READ: begin
        if (link_up) last_read_ms = w.now_ms;
      end
      REQ_PONG: begin
        if (link_up) begin
          dt = w.now_ms - w.pong_time_ms;
          dl = {{(64 - TIME_BITS){dt[TIME_BITS-1]}}, dt};
          d = (dl > RTT_HI) ? int'(RTT_HI) : (dl < RTT_LO) ? int'(RTT_LO) : int'(dl);
          last_pong_ms = w.now_ms;
          rtt_now = d;
          if (rtt_min > d) rtt_min = d;
          if (rtt_max < d && 20 * longint'(d) < longint'(cfg_period)) rtt_max = d;
          retries_left = cfg_retries;
        end
      end
      REQ_CONNECT: link_up = 1'b1;
      REQ_DISCONNECT: clear_link_state();
      default: ;
    endcase
    r.rtt_ms = rtt_now;
    r.min_rtt_ms = rtt_min;
    r.max_rtt_ms = rtt_max;
    r.retries_left = retries_left;
    r.idle_time_ms = idle_ms;
    r.work_time_ms = work_ms;
    return r;
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  function automatic void queue_event(logic [2:0] kind, logic [TIME_BITS-1:0] now,
                                      logic [TIME_BITS-1:0] pong);
    item_t w;
    w.req_type = kind;
    w.now_ms = now;
    w.pong_time_ms = pong;
    pending_events.push_back(w);
    queued_events++;
  endfunction

  // time to the next tick: mostly about one period, sometimes early, sometimes long silence
  function automatic int unsigned tick_gap();
    int unsigned p;
    int unsigned pick;
    p = cfg_period;
    pick = $urandom_range(0, 9);
    if (pick < 6) return p + $urandom_range(0, p / 8);
    if (pick < 8) return $urandom_range(0, p);
    return p * $urandom_range(2, 12);
  endfunction

  task automatic queue_session();
    int unsigned p;
    int unsigned pick;
    int steps;
    p = cfg_period;
    steps = $urandom_range(6, 30);
    queue_event(REQ_CONNECT, t_now, rand_time());
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        t_now += tick_gap();
        queue_event(REQ_TICK, t_now, rand_time());
      end else if (pick < 65) begin
        t_now += $urandom_range(0, p);
        queue_event(REQ_READ, t_now, rand_time());
      end else if (pick < 90) begin
        t_now += $urandom_range(0, p / 4);
        case ($urandom_range(0, 9))
          7: queue_event(REQ_PONG, t_now, t_now - $urandom_range(0, 2 * p));
          8: queue_event(REQ_PONG, t_now, t_now + $urandom_range(1, 1000));
          9: queue_event(REQ_PONG, t_now, rand_time());
          default: queue_event(REQ_PONG, t_now, t_now - $urandom_range(0, p / 16 + 1));
        endcase
      end else if (pick < 94) begin
        queue_event(REQ_CONNECT, t_now, rand_time());
      end else if (pick < 97) begin
        queue_event(3'($urandom_range(REQ_DISCONNECT + 1, 7)), t_now, rand_time());
      end else begin
        queue_event(REQ_DISCONNECT, t_now, rand_time());
      end
    end
    if ($urandom_range(0, 3) != 0) queue_event(REQ_DISCONNECT, t_now, rand_time());
  endtask

  task automatic program_reg(reg_idx_t idx, logic [31:0] val);
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_PERIOD) begin
      cfg_period = val[15:0];
      if (got[15:0] !== val[15:0]) begin
        $error("heartbeat_period_ms readback: expected %0h, got %0h", val[15:0], got[15:0]);
        fails++;
      end
    end else begin
      cfg_retries = val[3:0];
      if (got[3:0] !== val[3:0]) begin
        $error("max_retries readback: expected %0h, got %0h", val[3:0], got[3:0]);
        fails++;
      end
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_events.size() != 0 || item_valid || status_due.size() != 0);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  // event driver: bursts of words separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        item <= pending_events.pop_front();
        item_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    item_fire <= item_valid && item_ready && !rst;
    if (!rst && item_valid && item_ready) begin
      status_due.push_back(keepalive_step(item));
      events_in++;
    end
  end

  // receiver stall pattern, switching mode at random as rx_tick runs
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 97 == 0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: result_ready <= 1'b1;
        1: result_ready <= 1'($urandom_range(0, 1));
        2: result_ready <= ($urandom_range(0, 3) == 0);
        default: result_ready <= rx_tick[3];
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      status_seen++;
      if (result.send_ping === 1'b1) pings_seen++;
      if (result.drop_link === 1'b1) drops_seen++;
      if (status_due.size() == 0) begin
        $error("status word with no event pending");
        fails++;
      end else begin
        want = status_due.pop_front();
        check_field("send_ping", want.send_ping, result.send_ping);
        check_field("drop_link", want.drop_link, result.drop_link);
        check_field("rtt_ms", want.rtt_ms, result.rtt_ms);
        check_field("min_rtt_ms", want.min_rtt_ms, result.min_rtt_ms);
        check_field("max_rtt_ms", want.max_rtt_ms, result.max_rtt_ms);
        check_field("retries_left", want.retries_left, result.retries_left);
        check_field("idle_time_ms", want.idle_time_ms, result.idle_time_ms);
        check_field("work_time_ms", want.work_time_ms, result.work_time_ms);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d status words outstanding", cycles,
               status_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int mark;
    logic [31:0] period_sel;
    logic [31:0] retries_sel;
    cfg_period = PERIOD_RST;
    cfg_retries = RETRIES_RST;
    clear_link_state();
    idle_ms = '0;
    work_ms = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: ignored events, undefined codes, retry/rtt corners, drop, time wrap
    queue_event(REQ_TICK, '0, '0);
    queue_event(REQ_READ, 48'd100, '0);
    queue_event(REQ_PONG, 48'd200, 48'd150);
    for (int k = REQ_DISCONNECT + 1; k < 8; k++) queue_event(3'(k), '1, '1);
    queue_event(REQ_CONNECT, '0, '0);
    queue_event(REQ_TICK, 48'd1000, '0);
    queue_event(REQ_TICK, 48'd2000, '0);
    queue_event(REQ_PONG, 48'd2050, 48'd2000);
    queue_event(REQ_PONG, 48'd2060, 48'd2055);
    queue_event(REQ_TICK, 48'd3000, '0);
    queue_event(REQ_TICK, 48'd5000, '0);
    queue_event(REQ_READ, 48'd5500, '0);
    queue_event(REQ_TICK, 48'd6000, '0);
    queue_event(REQ_PONG, 48'd6100, 48'd6200);
    queue_event(REQ_PONG, 48'd6200, 48'd6200 - (48'd1 << 40));
    queue_event(REQ_PONG, 48'd6300, 48'd6300 + (48'd1 << 40));
    queue_event(REQ_PONG, 48'd6400, 48'd6400 ^ (48'd1 << 47));
    queue_event(REQ_TICK, 48'd7400, '0);
    queue_event(REQ_TICK, 48'd8400, '0);
    queue_event(REQ_TICK, 48'd9400, '0);
    queue_event(REQ_TICK, 48'd10400, '0);
    queue_event(REQ_CONNECT, '1, '0);
    queue_event(REQ_READ, 48'hFFFF_FFFF_FF9C, '0);
    queue_event(REQ_TICK, 48'd50, '1);
    queue_event(REQ_PONG, '1, '1);
    queue_event(REQ_DISCONNECT, '1, '1);
    wait_drained();

    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: begin period_sel = 32'd1; retries_sel = 32'd0; end
        2: begin period_sel = 32'd65535; retries_sel = 32'd15; end
        3: begin period_sel = 32'd250; retries_sel = 32'd1; end
        4: begin period_sel = $urandom_range(2, 5000); retries_sel = $urandom_range(0, 15); end
        default: begin period_sel = PERIOD_RST; retries_sel = RETRIES_RST; end
      endcase
      program_reg(REG_PERIOD, period_sel);
      program_reg(REG_RETRIES, retries_sel);
      t_now = ($urandom_range(0, 3) == 0) ? rand_time() : 48'd0;
      mark = queued_events;
      while (queued_events - mark < EVENTS_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4)) queue_event(3'($urandom_range(0, 7)), rand_time(),
                                                    rand_time());
        end else begin
          queue_session();
        end
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d status words for %0d event words over 6 register settings;",
             status_seen, events_in);
    $display("  %0d pings and %0d link drops observed.", pings_seen, drops_seen);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
